### rtl/core/lcd_window_pixel_writer_macros.svh
// Assertion helpers for the LCD window pixel writer.
`ifndef LCD_WINDOW_PIXEL_WRITER_MACROS_SVH
`define LCD_WINDOW_PIXEL_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LWPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcd window pixel writer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LWPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcd window pixel writer: next-cycle check failed");

`else

`define LWPW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LWPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/lcdwpw_pkg.sv
package lcdwpw_pkg;

    localparam int COLOR_W = 16;
    localparam int RGB_W   = 24;
    localparam int ADDR_W  = 17;
    localparam int POS_W   = 9;
    localparam int SIZE_W  = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    localparam logic [POS_W-1:0]  WIN_X_RST = 9'd0;
    localparam logic [POS_W-1:0]  WIN_Y_RST = 9'd0;
    localparam logic [SIZE_W-1:0] WIN_W_RST = 10'd128;
    localparam logic [SIZE_W-1:0] WIN_H_RST = 10'd160;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_X = 8'd0,
        REG_WIN_Y = 8'd1,
        REG_WIN_W = 8'd2,
        REG_WIN_H = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              written;
        logic [ADDR_W-1:0] pixel_address;
        logic [RGB_W-1:0]  rgb;
    } t_pix_result;

    // RGB565 to RGB888, low bits of each channel left at zero.
    function automatic logic [RGB_W-1:0] rgb565_to_888(input logic [COLOR_W-1:0] c);
        return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

endpackage

### rtl/core/lcd_window_pixel_writer.sv
// LCD window pixel writer: RGB565 pixel in, RGB888 frame-buffer write out.
// An accepted pixel request's result is registered in the output register, or first in the skid under a result stall.
// Throughput: 1 pixel per cycle while the skid entry is free; cursor step and address multiply are combinational.
// Output register plus skid: input runs on for one request under a result stall.
// Reset (sync, active low): window 0,0 128x160, cursor at origin, queue empty.
`include "lcd_window_pixel_writer_macros.svh"

module lcd_window_pixel_writer
    import lcdwpw_pkg::*;
#(
    parameter int PANEL_W = 128,
    parameter int PANEL_H = 160,
    parameter int FRAME_W = 240,
    parameter int FRAME_H = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COLOR_W-1:0]    i_color,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_written,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [RGB_W-1:0]      o_rgb,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Panel is centered in the frame. Offsets are taken modulo the address
    // width, so a panel larger than the frame still wraps around.
    localparam logic [ADDR_W-1:0] OFF_X   = ADDR_W'(FRAME_W / 2 - PANEL_W / 2);
    localparam logic [ADDR_W-1:0] OFF_Y   = ADDR_W'(FRAME_H / 2 - PANEL_H / 2);
    localparam logic [ADDR_W-1:0] FRAME_STRIDE = ADDR_W'(FRAME_W);
    localparam logic [SIZE_W-1:0] PANEL_W_LIM  = SIZE_W'(PANEL_W);
    localparam logic [SIZE_W-1:0] PANEL_H_LIM  = SIZE_W'(PANEL_H);

    // window registers and cursor
    logic [POS_W-1:0]  r_win_x, n_win_x;
    logic [POS_W-1:0]  r_win_y, n_win_y;
    logic [SIZE_W-1:0] r_win_w, n_win_w;
    logic [SIZE_W-1:0] r_win_h, n_win_h;
    logic [POS_W-1:0]  r_cur_col, n_cur_col;
    logic [POS_W-1:0]  r_cur_row, n_cur_row;

    // output queue: head register drives the ports, skid catches one more
    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_pix_result r_out, n_out;
    t_pix_result r_skid, n_skid;

    logic        in_accept;
    logic        out_take;
    logic        cfg_write;
    logic        cfg_hit;
    logic [SIZE_W:0] col_end;
    logic [SIZE_W:0] row_end;
    logic [SIZE_W:0] col_inc;
    logic [SIZE_W:0] row_inc;
    logic        in_window;
    logic [ADDR_W-1:0] row_base;
    logic [ADDR_W-1:0] pix_addr;
    t_pix_result new_res;

    // Hold off new requests only once the skid entry is occupied.
    assign o_stall     = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    assign o_valid         = r_out_valid;
    assign o_written       = r_out.written;
    assign o_pixel_address = r_out.pixel_address;
    assign o_rgb           = r_out.rgb;

    // Window edges are one past the last column/row, computed without wrap.
    assign col_end = {2'b00, r_win_x} + {1'b0, r_win_w};
    assign row_end = {2'b00, r_win_y} + {1'b0, r_win_h};
    assign col_inc = {2'b00, r_cur_col} + 11'd1;
    assign row_inc = {2'b00, r_cur_row} + 11'd1;

    assign in_window = (r_cur_col >= r_win_x) && ({2'b00, r_cur_col} < col_end) &&
                       (r_cur_row >= r_win_y) && ({2'b00, r_cur_row} < row_end) &&
                       ({1'b0, r_cur_col} < PANEL_W_LIM) &&
                       ({1'b0, r_cur_row} < PANEL_H_LIM);

    // Frame address: one multiply by the frame stride, then add column offset.
    assign row_base = ADDR_W'(r_cur_row) + OFF_Y;
    assign pix_addr = row_base * FRAME_STRIDE + ADDR_W'(r_cur_col) + OFF_X;

    // Out-of-range pixels report not written with zeroed payload.
    always_comb begin
        new_res = '0;
        if (in_window) begin
            new_res.written       = 1'b1;
            new_res.pixel_address = pix_addr;
            new_res.rgb           = rgb565_to_888(i_color);
        end
    end

    // Configuration decode and cursor advance. A write to a mapped register wins
    // over a pixel's cursor step. Writes must arrive only while the block is idle; the block does not enforce this.
    always_comb begin
        n_win_x   = r_win_x;
        n_win_y   = r_win_y;
        n_win_w   = r_win_w;
        n_win_h   = r_win_h;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        cfg_hit   = 1'b0;

        if (cfg_write) begin
            unique case (i_cfg_index)
                REG_WIN_X: begin
                    n_win_x = i_cfg_data[POS_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_WIN_Y: begin
                    n_win_y = i_cfg_data[POS_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_WIN_W: begin
                    n_win_w = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                REG_WIN_H: begin
                    n_win_h = i_cfg_data;
                    cfg_hit = 1'b1;
                end
                default: begin
                    // drop writes beyond the register list
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit) begin
            // reload cursor to the (possibly new) origin
            n_cur_col = n_win_x;
            n_cur_row = n_win_y;
        end else if (in_accept && in_window) begin
            // step right, wrap to next row, then back to the top
            if (col_inc == col_end) begin
                n_cur_col = r_win_x;
                if (row_inc == row_end) begin
                    n_cur_row = r_win_y;
                end else begin
                    n_cur_row = row_inc[POS_W-1:0];
                end
            end else begin
                n_cur_col = col_inc[POS_W-1:0];
            end
        end
    end

    // Output queue control: keep request order, skid drains first.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;

        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                n_out       = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = new_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x      <= WIN_X_RST;
            r_win_y      <= WIN_Y_RST;
            r_win_w      <= WIN_W_RST;
            r_win_h      <= WIN_H_RST;
            r_cur_col    <= WIN_X_RST;
            r_cur_row    <= WIN_Y_RST;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_win_x      <= n_win_x;
            r_win_y      <= n_win_y;
            r_win_w      <= n_win_w;
            r_win_h      <= n_win_h;
            r_cur_col    <= n_cur_col;
            r_cur_row    <= n_cur_row;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // A skid entry only exists behind a waiting head entry.
    `LWPW_ASSERT_NOW(a_skid_behind_head, i_clk, i_rst_n, r_skid_valid, r_out_valid)

    // Unwritten results carry zero address and color.
    `LWPW_ASSERT_NOW(a_unwritten_zero, i_clk, i_rst_n, r_out_valid && !r_out.written,
        (r_out.pixel_address == '0) && (r_out.rgb == '0))

    // A pixel outside the window leaves the cursor where it was.
    `LWPW_ASSERT_NEXT(a_hold_outside, i_clk, i_rst_n, in_accept && !in_window && !cfg_write,
        $stable(r_cur_col) && $stable(r_cur_row))

    // Writing the left column register reloads the cursor column from it.
    `LWPW_ASSERT_NEXT(a_reload_col, i_clk, i_rst_n, cfg_write && (i_cfg_index == REG_WIN_X),
        r_cur_col == $past(i_cfg_data[POS_W-1:0]))

endmodule

### test/lcd_window_pixel_writer_checker.sv
module lcd_window_pixel_writer_checker
    import lcdwpw_pkg::*;
#(
    parameter int PANEL_W = 128,
    parameter int PANEL_H = 160,
    parameter int FRAME_W = 240,
    parameter int FRAME_H = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_stall,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic                  i_written,
    input  logic [ADDR_W-1:0]     i_pixel_address,
    input  logic [RGB_W-1:0]      i_rgb,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_writes
);

    localparam int unsigned OFF_X = FRAME_W / 2 - PANEL_W / 2;
    localparam int unsigned OFF_Y = FRAME_H / 2 - PANEL_H / 2;

    logic [POS_W-1:0]  win_x;
    logic [POS_W-1:0]  win_y;
    logic [SIZE_W-1:0] win_w;
    logic [SIZE_W-1:0] win_h;
    logic [POS_W-1:0]  cur_col;
    logic [POS_W-1:0]  cur_row;

    t_pix_result pixel_q[$];

    int fail_total   = 0;
    int result_total = 0;
    int write_total  = 0;
    int queue_depth  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = queue_depth;
    assign o_results    = result_total;
    assign o_writes     = write_total;

    // Work out the frame-buffer write for one pixel and advance the cursor.
    function automatic t_pix_result paint_pixel(input logic [COLOR_W-1:0] color);
        int unsigned col_end;
        int unsigned row_end;
        int unsigned addr;
        int unsigned c;
        t_pix_result res;
        col_end = 32'(win_x) + 32'(win_w);
        row_end = 32'(win_y) + 32'(win_h);
        res = '0;
        if (cur_col >= win_x && 32'(cur_col) < col_end
                && cur_row >= win_y && 32'(cur_row) < row_end
                && 32'(cur_col) < PANEL_W && 32'(cur_row) < PANEL_H) begin
            c    = 32'(color);
            addr = (32'(cur_row) + OFF_Y) * FRAME_W + 32'(cur_col) + OFF_X;
            res.written       = 1'b1;
            res.pixel_address = addr[ADDR_W-1:0];
            res.rgb = 24'(((c & 32'hF800) << 8) | ((c & 32'h07E0) << 5) | ((c & 32'h001F) << 3));
            if (32'(cur_col) + 1 == col_end) begin
                cur_col = win_x;
                if (32'(cur_row) + 1 == row_end) begin
                    cur_row = win_y;
                end else begin
                    cur_row = cur_row + 1'b1;
                end
            end else begin
                cur_col = cur_col + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, result_total);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_pix_result want;
        logic        reload;
        if (!i_rst_n) begin
            win_x   = WIN_X_RST;
            win_y   = WIN_Y_RST;
            win_w   = WIN_W_RST;
            win_h   = WIN_H_RST;
            cur_col = WIN_X_RST;
            cur_row = WIN_Y_RST;
            pixel_q.delete();
        end else begin
            // Compare first: a result never leaves in the cycle its request enters.
            if (i_res_valid && !i_res_stall) begin
                result_total++;
                if (pixel_q.size() == 0) begin
                    report_mismatch("result with no request pending", 32'(i_written), 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (want.written) write_total++;
                    if (i_written !== want.written)
                        report_mismatch("written", 32'(i_written), 32'(want.written));
                    if (i_pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", 32'(i_pixel_address),
                                        32'(want.pixel_address));
                    if (i_rgb !== want.rgb)
                        report_mismatch("rgb", 32'(i_rgb), 32'(want.rgb));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                reload = 1'b1;
                case (i_cfg_index)
                    REG_WIN_X: win_x = i_cfg_data[POS_W-1:0];
                    REG_WIN_Y: win_y = i_cfg_data[POS_W-1:0];
                    REG_WIN_W: win_w = i_cfg_data;
                    REG_WIN_H: win_h = i_cfg_data;
                    default:   reload = 1'b0;
                endcase
                if (reload) begin
                    cur_col = win_x;
                    cur_row = win_y;
                end
            end
            if (i_pix_valid && !i_pix_stall) pixel_q.push_back(paint_pixel(i_color));
        end
        queue_depth <= pixel_q.size();
    end

endmodule

### test/testbench.sv
module testbench;
    import lcdwpw_pkg::*;

    localparam int PANEL_W = 128;
    localparam int PANEL_H = 160;
    localparam int FRAME_W = 240;
    localparam int FRAME_H = 320;

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ROUNDS = 12;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [COLOR_W-1:0]    i_color     = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic              o_stall;
    logic              o_valid;
    logic              o_written;
    logic [ADDR_W-1:0] o_pixel_address;
    logic [RGB_W-1:0]  o_rgb;
    logic              o_cfg_ready;

    int fail_count;
    int pending;
    int result_count;
    int write_count;

    // Percent chance per cycle that the sender holds off / the receiver stalls.
    int idle_pct       = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;
    int requests_sent  = 0;
    int settings_used  = 0;

    always #5 i_clk = ~i_clk;

    lcd_window_pixel_writer #(
        .PANEL_W(PANEL_W),
        .PANEL_H(PANEL_H),
        .FRAME_W(FRAME_W),
        .FRAME_H(FRAME_H)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_written      (o_written),
        .o_pixel_address(o_pixel_address),
        .o_rgb          (o_rgb),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    lcd_window_pixel_writer_checker #(
        .PANEL_W(PANEL_W),
        .PANEL_H(PANEL_H),
        .FRAME_W(FRAME_W),
        .FRAME_H(FRAME_H)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (i_valid),
        .i_pix_stall    (o_stall),
        .i_color        (i_color),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_written      (o_written),
        .i_pixel_address(o_pixel_address),
        .i_rgb          (o_rgb),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (result_count),
        .o_writes       (write_count)
    );

    // Receiver back-pressure: redraw the stall every cycle from the current mix.
    always @(posedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: restart the count on any handshake, give up after a long silence.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results still pending",
                     WATCHDOG_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one register write and hold it until the block takes it.
    // Return at the accepting edge with valid still high, so back-to-back
    // writes never lower and raise valid in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Load a full window; optionally follow it with a write to an unmapped
    // index, which the block must drop without reloading the cursor.
    task automatic set_window(input logic [CFG_DATA_W-1:0] x, input logic [CFG_DATA_W-1:0] y,
                              input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input bit stray);
        write_reg(REG_WIN_X, x);
        write_reg(REG_WIN_Y, y);
        write_reg(REG_WIN_W, w);
        write_reg(REG_WIN_H, h);
        if (stray) write_reg(CFG_IDX_W'($urandom_range(REG_WIN_H + 1, 255)), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Send one pixel request, idling first at random, and hold it until taken.
    task automatic send_pixel(input logic [COLOR_W-1:0] color);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_color <= color;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every expected result is back, then let the
    // block settle, so the block is idle afterwards.
    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One random phase: pick a window, then stream pixels through it.
    task automatic run_round(input int count, input bit pause);
        int                    kind;
        logic [CFG_DATA_W-1:0] x;
        logic [CFG_DATA_W-1:0] y;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        kind = $urandom_range(9);
        if (kind <= 5) begin
            // small window starting inside the panel: many row and frame wraps
            x = CFG_DATA_W'($urandom_range(PANEL_W - 1));
            y = CFG_DATA_W'($urandom_range(PANEL_H - 1));
            w = CFG_DATA_W'($urandom_range(1, 12));
            h = CFG_DATA_W'($urandom_range(1, 6));
        end else if (kind <= 7) begin
            // window near the panel corner: cursor may run off and stick
            x = CFG_DATA_W'($urandom_range(PANEL_W - 8, PANEL_W - 1));
            y = CFG_DATA_W'($urandom_range(PANEL_H - 4, PANEL_H - 1));
            w = CFG_DATA_W'($urandom_range(1, 20));
            h = CFG_DATA_W'($urandom_range(1, 8));
        end else if (kind == 8) begin
            // raw register noise, excess bits and empty windows included
            x = CFG_DATA_W'($urandom);
            y = CFG_DATA_W'($urandom);
            w = CFG_DATA_W'($urandom);
            h = CFG_DATA_W'($urandom);
        end else begin
            x = CFG_DATA_W'($urandom_range(3));
            y = CFG_DATA_W'($urandom_range(3));
            w = CFG_DATA_W'($urandom_range(100, 512));
            h = CFG_DATA_W'($urandom_range(1, 512));
        end
        set_window(x, y, w, h, $urandom_range(3) == 0);
        for (int i = 0; i < count; i++) begin
            // Hold the stream until the block has drained completely.
            if (pause && i == count / 2) wait_results();
            send_pixel(COLOR_W'($urandom));
        end
        wait_results();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window: extremes and the red and green channels alone along row 0.
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hF800);
        send_pixel(16'h07E0);
        wait_results();

        // 2x2 window in the panel's bottom right corner: column, row and
        // frame wrap; an unmapped register write mid-stream must not reload.
        set_window(10'd126, 10'd158, 10'd2, 10'd2, 1'b0);
        send_pixel(16'h001F);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        wait_results();
        write_reg(CFG_IDX_W'(REG_WIN_H + 1), 10'h3FF);
        i_cfg_valid <= 1'b0;
        send_pixel(16'h0821);
        send_pixel(16'hF7DE);
        send_pixel(16'h8410);
        wait_results();

        // Window past the panel's right edge: one write, then the cursor holds.
        set_window(10'd127, 10'd0, 10'd3, 10'd1, 1'b0);
        repeat (3) send_pixel(COLOR_W'($urandom));
        wait_results();

        // Empty windows: zero width, then zero height.
        set_window(10'd0, 10'd0, 10'd0, 10'd1, 1'b0);
        repeat (2) send_pixel(16'hFFFF);
        wait_results();
        set_window(10'd0, 10'd0, 10'd1, 10'd0, 1'b0);
        send_pixel(16'hFFFF);
        wait_results();

        // All-ones register data: position bits above the register width drop.
        set_window(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1);
        send_pixel(16'hFFFF);
        wait_results();

        // Single-pixel window at the origin rewrites the same word.
        set_window(10'd0, 10'd0, 10'd1, 10'd1, 1'b0);
        repeat (3) send_pixel(COLOR_W'($urandom));
        wait_results();

        // Random phases; rotate through the flow-control mixes.
        for (int r = 0; r < ROUNDS; r++) begin
            case (r % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  = 73;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct <= 73;
                end
                default: begin
                    idle_pct  = 21;
                    stall_pct <= 21;
                end
            endcase
            run_round($urandom_range(50, 100), r == 1 || $urandom_range(3) == 0);
        end

        idle_pct  = 0;
        stall_pct <= 0;
        wait_results();
        repeat (4) @(posedge i_clk);

        $display("Summary: %0d pixel requests over %0d window settings, %0d results checked",
                 requests_sent, settings_used, result_count);
        $display("Summary: %0d frame-buffer writes, flow control free, sender-idle, "
                 , write_count, "receiver-stall and mixed");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### lcd_window_pixel_writer.f
+incdir+rtl/core
rtl/core/lcdwpw_pkg.sv
rtl/core/lcd_window_pixel_writer.sv
test/lcd_window_pixel_writer_checker.sv
test/testbench.sv
